FILE: rtl/gcs_pkg.sv
`timescale 1ns / 1ps
// Package for the greedy change dispenser: request codes, status codes,
// queue command and configuration types, register indexes and reset values.
// No dependencies.
package gcs_pkg;

    localparam int AMT_W      = 16;
    localparam int IDX_W      = 3;
    localparam int ACT_W      = IDX_W + 1;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int VALUE_REGS = 6;

    localparam logic [AMT_W-1:0] RESTOCK_ADD = 16'd10;
    localparam logic [AMT_W-1:0] AMT_MAX     = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_DENOM_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VALUE_FIRST = 3'd1;

    localparam logic [AMT_W-1:0] VALUE_RESET [VALUE_REGS] = '{
        16'd200, 16'd100, 16'd50, 16'd20, 16'd10, 16'd5
    };
    localparam logic [CNT_W-1:0] COUNT_RESET = 3'd6;

    typedef enum logic [1:0] {
        REQ_CHANGE  = 2'd0,
        REQ_RESTOCK = 2'd1,
        REQ_SET     = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_OUT_OF_STOCK = 2'd1,
        ST_NOT_EXACT    = 2'd2
    } t_status;

    typedef struct packed {
        t_req              op;
        logic [AMT_W-1:0]  amount;
        logic [IDX_W-1:0]  slot;
        logic [AMT_W-1:0]  value;
        logic              slot_ok;
    } t_cmd;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [VALUE_REGS-1:0][AMT_W-1:0] value;
    } t_cfg;

endpackage

FILE: rtl/gcs_fifo.sv
`timescale 1ns / 1ps
// Small synchronous queue between the request front end and the dispenser.
// Generic width and depth (depth of two or more); no package dependency.
module gcs_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int LVL_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [LVL_W-1:0] r_level;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_level == LVL_W'(DEPTH));
    assign o_empty = (r_level == '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_level  <= '0;
        end else begin
            if (push_ok) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_level <= r_level + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_level <= r_level - 1'b1;
            end
        end
    end

endmodule

FILE: rtl/gcs_front.sv
`timescale 1ns / 1ps
// Request front end: takes input transactions, classifies them into queue
// commands and drops unused request codes. Depends on gcs_pkg.
module gcs_front
    import gcs_pkg::*;
#(
    parameter int NUM_DENOMS = 6
) (
    input  logic             i_valid,
    output logic             o_stall,
    input  logic [1:0]       i_req_type,
    input  logic [AMT_W-1:0] i_amount,
    input  logic [IDX_W-1:0] i_slot_index,
    input  logic [AMT_W-1:0] i_stock_value,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    t_req req;

    assign req     = t_req'(i_req_type);
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full && (req != REQ_NONE);

    always_comb begin
        o_cmd.op      = req;
        o_cmd.amount  = i_amount;
        o_cmd.slot    = i_slot_index;
        o_cmd.value   = i_stock_value;
        o_cmd.slot_ok = ({1'b0, i_slot_index} < ACT_W'(NUM_DENOMS));
    end

endmodule

FILE: rtl/gcs_div.sv
`timescale 1ns / 1ps
// Iterative unsigned divider, two quotient bits per cycle, registered result.
// Depends on gcs_pkg for the operand width.
module gcs_div
    import gcs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [AMT_W-1:0] i_dividend,
    input  logic [AMT_W-1:0] i_divisor,
    output logic             o_done,
    output logic [AMT_W-1:0] o_quotient,
    output logic [AMT_W-1:0] o_remainder
);

    localparam int BITS_PER_STEP = 2;
    localparam int STEPS         = AMT_W / BITS_PER_STEP;
    localparam int STEP_W        = $clog2(STEPS);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [AMT_W-1:0]  r_quo;
    logic [AMT_W-1:0]  r_rem;
    logic [AMT_W-1:0]  r_div;
    logic [AMT_W-1:0]  n_quo;
    logic [AMT_W-1:0]  n_rem;
    logic [AMT_W:0]    trial;

    always_comb begin
        n_quo = r_quo;
        n_rem = r_rem;
        trial = '0;
        for (int k = 0; k < BITS_PER_STEP; k++) begin
            trial = {n_rem, n_quo[AMT_W-1]};
            n_quo = {n_quo[AMT_W-2:0], 1'b0};
            if (trial >= {1'b0, r_div}) begin
                trial    = trial - {1'b0, r_div};
                n_quo[0] = 1'b1;
            end
            n_rem = trial[AMT_W-1:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_div  <= i_divisor;
            end else if (r_busy) begin
                r_quo  <= n_quo;
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: rtl/gcs_back.sv
`timescale 1ns / 1ps
// Dispenser back end: coin stock, greedy walk over the denominations with a
// shared divider, and the registered result stage. Depends on gcs_pkg, gcs_div.
module gcs_back
    import gcs_pkg::*;
#(
    parameter int NUM_DENOMS = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_q_empty,
    input  t_cmd             i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [IDX_W-1:0] o_denom_index,
    output logic [AMT_W-1:0] o_coin_count,
    output logic [1:0]       o_status,
    output logic             o_last
);

    localparam int SEL_W = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_WAIT,
        S_FINISH,
        S_EMIT
    } t_state;

    t_state           r_state;
    t_cmd             r_cmd;
    logic [IDX_W-1:0] r_idx;
    logic [AMT_W-1:0] r_rem;
    t_status          r_status;
    logic [AMT_W-1:0] r_stock [NUM_DENOMS];
    logic [AMT_W-1:0] r_take  [NUM_DENOMS];
    logic             r_ovalid;
    logic [IDX_W-1:0] r_out_index;
    logic [AMT_W-1:0] r_out_count;
    t_status          r_out_status;
    logic             r_out_last;

    logic [ACT_W-1:0] n_act;
    logic             idx_last;
    logic [SEL_W-1:0] sel;
    logic [AMT_W-1:0] cur_value;
    logic [AMT_W:0]   restock_sum;
    logic [AMT_W-1:0] restock_val;
    logic             load;
    logic             div_start;
    logic             div_done;
    logic [AMT_W-1:0] div_q;
    logic [AMT_W-1:0] div_r;

    logic [IDX_W-1:0] emit_index;
    logic [AMT_W-1:0] emit_count;
    logic             emit_last;
    logic             emit_we;
    logic [SEL_W-1:0] emit_sel;
    logic [AMT_W-1:0] emit_stock;

    always_comb begin
        if (i_cfg.count == '0) begin
            n_act = ACT_W'(1);
        end else if ({1'b0, i_cfg.count} > ACT_W'(NUM_DENOMS)) begin
            n_act = ACT_W'(NUM_DENOMS);
        end else begin
            n_act = {1'b0, i_cfg.count};
        end
    end

    assign idx_last  = (({1'b0, r_idx} + ACT_W'(1)) == n_act);
    assign sel       = r_idx[SEL_W-1:0];
    assign cur_value = (r_idx < IDX_W'(VALUE_REGS)) ? i_cfg.value[r_idx] : '0;

    assign restock_sum = {1'b0, r_stock[sel]} + {1'b0, RESTOCK_ADD};
    assign restock_val = restock_sum[AMT_W] ? AMT_MAX : restock_sum[AMT_W-1:0];

    assign load      = (r_state == S_EMIT) && (!r_ovalid || !i_stall);
    assign o_pop     = (r_state == S_IDLE) && !i_q_empty;
    assign div_start = (r_state == S_WALK) && (cur_value != '0);

    gcs_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_rem),
        .i_divisor   (cur_value),
        .o_done      (div_done),
        .o_quotient  (div_q),
        .o_remainder (div_r)
    );

    always_comb begin
        emit_index = r_idx;
        emit_count = '0;
        emit_last  = idx_last;
        emit_we    = 1'b0;
        emit_sel   = sel;
        emit_stock = r_stock[sel];
        unique case (r_cmd.op)
            REQ_CHANGE: begin
                if (r_status == ST_OK) begin
                    emit_count = r_take[sel];
                    emit_we    = 1'b1;
                    emit_stock = r_stock[sel] - r_take[sel];
                end
            end
            REQ_RESTOCK: begin
                emit_count = restock_val;
                emit_we    = 1'b1;
                emit_stock = restock_val;
            end
            REQ_SET: begin
                emit_index = r_cmd.slot;
                emit_last  = 1'b1;
                emit_sel   = r_cmd.slot[SEL_W-1:0];
                emit_stock = r_cmd.value;
                if (r_cmd.slot_ok) begin
                    emit_count = r_cmd.value;
                    emit_we    = 1'b1;
                end
            end
            default: begin
                emit_last = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int j = 0; j < NUM_DENOMS; j++) begin
                r_stock[j] <= '0;
            end
        end else begin
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_cmd    <= i_cmd;
                        r_idx    <= '0;
                        r_rem    <= i_cmd.amount;
                        r_status <= ST_OK;
                        if (i_cmd.op == REQ_CHANGE) begin
                            r_state <= S_WALK;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_WALK: begin
                    if (cur_value == '0) begin
                        r_take[sel] <= '0;
                        if (idx_last) begin
                            r_state <= S_FINISH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (div_done) begin
                        if (div_q > r_stock[sel]) begin
                            r_status <= ST_OUT_OF_STOCK;
                            r_idx    <= '0;
                            r_state  <= S_EMIT;
                        end else begin
                            r_take[sel] <= div_q;
                            r_rem       <= div_r;
                            if (idx_last) begin
                                r_state <= S_FINISH;
                            end else begin
                                r_idx   <= r_idx + 1'b1;
                                r_state <= S_WALK;
                            end
                        end
                    end
                end
                S_FINISH: begin
                    if (r_rem != '0) begin
                        r_status <= ST_NOT_EXACT;
                    end
                    r_idx   <= '0;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (load) begin
                        r_out_index  <= emit_index;
                        r_out_count  <= emit_count;
                        r_out_status <= r_status;
                        r_out_last   <= emit_last;
                        if (emit_we) begin
                            r_stock[emit_sel] <= emit_stock;
                        end
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_denom_index = r_out_index;
    assign o_coin_count  = r_out_count;
    assign o_status      = r_out_status;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_fail_zero_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && (r_out_status != ST_OK) |-> (r_out_count == '0))
        else $error("failed change result carries coins");

    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_WAIT))
        else $error("divider finished outside the wait state");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK || r_state == S_WAIT) |-> ({1'b0, r_idx} < n_act))
        else $error("denomination index beyond active count");

    a_no_restart_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT) && !div_done |=> (r_state == S_WAIT))
        else $error("walk advanced without a divider result");
`endif

endmodule

FILE: rtl/greedy_change_with_stock.sv
`timescale 1ns / 1ps
// Top level of the greedy change dispenser: configuration registers, request
// front end, command queue and dispenser back end. Depends on gcs_pkg,
// gcs_fifo, gcs_front, gcs_back.
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------
//  request | in        | i_valid / o_stall   | req_type, amount, slot_index, stock_value
//  result  | out       | o_valid / i_stall   | denom_index, coin_count, status, last
//  config  | in        | i_cfg_we            | i_cfg_index, i_cfg_data
//
// Make change: the command is taken from the queue; then each denomination walked
// starts the radix-4 divider and checks its result when its value is nonzero, and
// is skipped when zero; then a decision step (skipped on out of stock) and one
// result per denomination. Restock: one result per active denomination; set stock: one.
// The walk uses a shared divider; the back end works one request at a time.
// Reset is synchronous: stock cleared, denomination registers to defaults.
// A two-entry queue lets requests be taken while results are stalled.
module greedy_change_with_stock
    import gcs_pkg::*;
#(
    parameter int NUM_DENOMS = 6
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [1:0]           i_req_type,
    input  logic [AMT_W-1:0]     i_amount,
    input  logic [IDX_W-1:0]     i_slot_index,
    input  logic [AMT_W-1:0]     i_stock_value,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [IDX_W-1:0]     o_denom_index,
    output logic [AMT_W-1:0]     o_coin_count,
    output logic [1:0]           o_status,
    output logic                 o_last,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [AMT_W-1:0]     i_cfg_data
);

    localparam int QUEUE_DEPTH = 2;

    t_cfg r_cfg;
    t_cmd front_cmd;
    t_cmd queue_cmd;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.count <= COUNT_RESET;
            for (int j = 0; j < VALUE_REGS; j++) begin
                r_cfg.value[j] <= VALUE_RESET[j];
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_DENOM_COUNT) begin
                r_cfg.count <= i_cfg_data[CNT_W-1:0];
            end
            for (int j = 0; j < VALUE_REGS; j++) begin
                if (i_cfg_index == (CFG_VALUE_FIRST + CFG_IDX_W'(j))) begin
                    r_cfg.value[j] <= i_cfg_data;
                end
            end
        end
    end

    gcs_front #(
        .NUM_DENOMS (NUM_DENOMS)
    ) u_front (
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_req_type    (i_req_type),
        .i_amount      (i_amount),
        .i_slot_index  (i_slot_index),
        .i_stock_value (i_stock_value),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (front_cmd)
    );

    gcs_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (queue_cmd),
        .o_empty (q_empty)
    );

    gcs_back #(
        .NUM_DENOMS (NUM_DENOMS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_q_empty     (q_empty),
        .i_cmd         (queue_cmd),
        .o_pop         (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_denom_index (o_denom_index),
        .o_coin_count  (o_coin_count),
        .o_status      (o_status),
        .o_last        (o_last)
    );

endmodule
